// File: rtl/core/tsuf_pkg.sv
// ----------------------------------------------------------------------------
// tsuf_pkg
// Shared types and constants for the urgent-first token scheduler.
// ----------------------------------------------------------------------------
package tsuf_pkg;
  localparam int GUEST_COUNT = 16;
  localparam int GW = $clog2(GUEST_COUNT);
  localparam int CW = $clog2(GUEST_COUNT + 1);
  localparam int TICK_WIDTH = 20;
  localparam logic [TICK_WIDTH-1:0] HOLD_RESET = TICK_WIDTH'(20000);
  localparam logic [TICK_WIDTH-1:0] TICK_MAX = '1;

  localparam logic [2:0] REQ_ENTER = 3'd0;
  localparam logic [2:0] REQ_CHECK = 3'd1;
  localparam logic [2:0] REQ_BBEGIN = 3'd2;
  localparam logic [2:0] REQ_BEND = 3'd3;
  localparam logic [2:0] REQ_RELEASE = 3'd4;
  localparam logic [2:0] REQ_STOP = 3'd5;
  localparam logic [2:0] REQ_TICK = 3'd6;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_CANCEL = 2'd1;
  localparam logic [1:0] ST_ACTIVE = 2'd2;
  localparam logic [1:0] ST_NOTOWN = 2'd3;

  localparam logic [1:0] CFG_QUANTUM = 2'd0;
  localparam logic [1:0] CFG_HOLD = 2'd1;
  localparam logic [1:0] CFG_MASK = 2'd2;

  typedef enum logic [1:0] {S_IDLE, S_EVENT, S_GRANT, S_OUT} state_t;

  typedef struct packed {
    logic load;   // capture input transaction
    logic event_step;
    logic grant_step;
  } cmd_t;

  typedef struct packed {
    logic [1:0]    status;
    logic          grant_valid;
    logic [GW-1:0] granted_guest;
    logic          owner_valid;
    logic [GW-1:0] owner_guest;
  } result_t;
endpackage

// File: rtl/core/tsuf_ctrl.sv
// ----------------------------------------------------------------------------
// tsuf_ctrl
// Sequencer: load, event update, grant, then hold the result until taken.
// ----------------------------------------------------------------------------
module tsuf_ctrl import tsuf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_fire,
  input  logic out_fire,
  output logic in_ready,
  output logic out_valid,
  output cmd_t cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_fire) state_nxt = S_EVENT;
      S_EVENT: state_nxt = S_GRANT;
      S_GRANT: state_nxt = S_OUT;
      S_OUT:   if (out_fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state_r == S_IDLE);
    out_valid = (state_r == S_OUT);
    cmd.load = in_fire;
    cmd.event_step = (state_r == S_EVENT);
    cmd.grant_step = (state_r == S_GRANT);
  end

  ap_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.event_step && cmd.grant_step)) else $error("overlapping steps");
  ap_ev_grant: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.event_step |=> cmd.grant_step) else $error("grant skipped");
  ap_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_fire |=> out_valid) else $error("result dropped");
endmodule

// File: rtl/core/tsuf_dp.sv
// ----------------------------------------------------------------------------
// tsuf_dp
// Queue shift chain, ownership and tick state, configuration registers.
// ----------------------------------------------------------------------------
module tsuf_dp import tsuf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  input  logic [2:0]            in_req,
  input  logic [GW-1:0]         in_guest,
  input  logic                  in_handoff,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_idx,
  input  logic [TICK_WIDTH-1:0] cfg_val,
  output result_t               res
);
  logic [TICK_WIDTH-1:0] quantum_r, hold_r, run_r, run_nxt;
  logic [GUEST_COUNT-1:0] mask_r, ub_r, ub_nxt, blk_r, blk_nxt;
  logic [GW-1:0] ids_r [GUEST_COUNT];
  logic [GW-1:0] ids_nxt [GUEST_COUNT];
  logic [CW-1:0] cnt_r, cnt_nxt, uw_r, uw_nxt;
  logic hv_r, hv_nxt, hu_r, hu_nxt, stop_r, stop_nxt;
  logic [GW-1:0] holder_r, holder_nxt;
  logic [2:0] req_r;
  logic [GW-1:0] g_r;
  logic ho_r;
  logic [1:0] status_r, status_nxt;
  logic gv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r <= '0; hold_r <= HOLD_RESET; mask_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_QUANTUM: quantum_r <= cfg_val;
        CFG_HOLD:    hold_r <= cfg_val;
        CFG_MASK:    mask_r <= cfg_val[GUEST_COUNT-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req; g_r <= in_guest; ho_r <= in_handoff;
    end
  end

  // Queue membership and urgent insertion point.
  logic inq;
  logic [CW-1:0] upos;
  always_comb begin
    inq = 1'b0;
    upos = cnt_r;
    for (int i = GUEST_COUNT - 1; i >= 0; i--) begin
      if (CW'(i) < cnt_r && !ub_r[i]) upos = CW'(i);
    end
    for (int i = 0; i < GUEST_COUNT; i++) begin
      if (CW'(i) < cnt_r && ids_r[i] == g_r) inq = 1'b1;
    end
  end

  logic owner, full;
  assign owner = hv_r && holder_r == g_r;
  assign full = cnt_r == CW'(GUEST_COUNT);

  always_comb begin
    logic enq, urg, fast;
    enq = 1'b0; urg = 1'b0; fast = 1'b0;
    ids_nxt = ids_r; ub_nxt = ub_r; cnt_nxt = cnt_r; uw_nxt = uw_r;
    blk_nxt = blk_r; hv_nxt = hv_r; hu_nxt = hu_r; holder_nxt = holder_r;
    run_nxt = run_r; stop_nxt = stop_r; status_nxt = status_r;
    if (cmd.event_step) begin
      status_nxt = ST_OK;
      unique case (req_r)
        REQ_ENTER: begin
          if (stop_r) status_nxt = ST_CANCEL;
          else if (owner || inq || blk_r[g_r]) status_nxt = ST_ACTIVE;
          else begin enq = 1'b1; urg = mask_r[g_r]; end
        end
        REQ_CHECK: begin
          if (!owner) status_nxt = ST_NOTOWN;
          else if (stop_r) status_nxt = ST_CANCEL;
          else if (ho_r) begin
            fast = quantum_r != '0 && (hu_r || uw_r == '0) && run_r < quantum_r;
            if (!fast) begin
              if (cnt_r == '0) run_nxt = '0;
              else if (!(hu_r && run_r < hold_r)) begin
                enq = 1'b1; hv_nxt = 1'b0;
              end
            end
          end
        end
        REQ_BBEGIN: begin
          if (!owner) status_nxt = ST_NOTOWN;
          else if (stop_r) status_nxt = ST_CANCEL;
          else begin blk_nxt[g_r] = 1'b1; hv_nxt = 1'b0; end
        end
        REQ_BEND: begin
          if (!blk_r[g_r]) status_nxt = ST_NOTOWN;
          else begin
            blk_nxt[g_r] = 1'b0;
            if (stop_r) status_nxt = ST_CANCEL;
            else begin enq = 1'b1; urg = mask_r[g_r]; end
          end
        end
        REQ_RELEASE: begin
          if (!owner) status_nxt = ST_NOTOWN;
          else hv_nxt = 1'b0;
        end
        REQ_STOP: begin
          stop_nxt = 1'b1; cnt_nxt = '0; uw_nxt = '0; ub_nxt = '0;
        end
        REQ_TICK: if (hv_r && run_r != TICK_MAX) run_nxt = run_r + 1'b1;
        default: ;
      endcase
      if (enq && !full) begin
        if (urg) begin
          // Shift the entries behind the insertion point back by one.
          for (int i = 1; i < GUEST_COUNT; i++) begin
            if (CW'(i) > upos && CW'(i) <= cnt_r) begin
              ids_nxt[i] = ids_r[i-1]; ub_nxt[i] = ub_r[i-1];
            end
          end
          for (int i = 0; i < GUEST_COUNT; i++) begin
            if (CW'(i) == upos) begin
              ids_nxt[i] = g_r; ub_nxt[i] = 1'b1;
            end
          end
          uw_nxt = uw_r + 1'b1;
        end else begin
          ids_nxt[cnt_r[GW-1:0]] = g_r; ub_nxt[cnt_r[GW-1:0]] = 1'b0;
        end
        cnt_nxt = cnt_r + 1'b1;
      end
    end
    if (cmd.grant_step) begin
      if (!hv_r && !stop_r && cnt_r != '0) begin
        holder_nxt = ids_r[0];
        if (ub_r[0] && uw_r != '0) uw_nxt = uw_r - 1'b1;
        for (int i = 0; i < GUEST_COUNT - 1; i++) begin
          ids_nxt[i] = ids_r[i+1]; ub_nxt[i] = ub_r[i+1];
        end
        ub_nxt[GUEST_COUNT-1] = 1'b0;
        ub_nxt[cnt_r[GW-1:0] - 1'b1] = 1'b0;
        cnt_nxt = cnt_r - 1'b1;
        hv_nxt = 1'b1; run_nxt = '0; hu_nxt = mask_r[ids_r[0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    ids_r <= ids_nxt;
    if (!rst_n) begin
      ub_r <= '0; cnt_r <= '0; uw_r <= '0; blk_r <= '0; hv_r <= 1'b0;
      hu_r <= 1'b0; holder_r <= '0; run_r <= '0; stop_r <= 1'b0;
      status_r <= ST_OK; gv_r <= 1'b0;
    end else begin
      ub_r <= ub_nxt; cnt_r <= cnt_nxt; uw_r <= uw_nxt; blk_r <= blk_nxt;
      hv_r <= hv_nxt; hu_r <= hu_nxt; holder_r <= holder_nxt; run_r <= run_nxt;
      stop_r <= stop_nxt; status_r <= status_nxt;
      if (cmd.event_step) gv_r <= 1'b0;
      if (cmd.grant_step) gv_r <= hv_nxt && !hv_r;
    end
  end

  assign res.status = status_r;
  assign res.grant_valid = gv_r;
  assign res.granted_guest = gv_r ? holder_r : '0;
  assign res.owner_valid = hv_r;
  assign res.owner_guest = hv_r ? holder_r : '0;

  ap_uw: assert property (@(posedge clk) disable iff (!rst_n)
    uw_r <= cnt_r) else $error("urgent count exceeds queue");
  ap_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(GUEST_COUNT)) else $error("queue overflow");
  ap_stop: assert property (@(posedge clk) disable iff (!rst_n)
    stop_r && cmd.grant_step |=> !gv_r) else $error("grant while stopping");
endmodule

// File: rtl/core/token_scheduler_urgent_fifo_top.sv
// ----------------------------------------------------------------------------
// token_scheduler_urgent_fifo_top
// Token scheduler with an urgent-first ready queue, stream interface.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one scheduling event per transaction (request, guest, handoff).
//   out_* : one result per event: status, grant and current owner.
//   cfg_* : register writes (0 quantum, 1 urgent hold, 2 urgent mask),
//           always accepted; write only while no event is in flight.
// Timing: an event is accepted in IDLE, updates state in the next cycle,
//   resolves the grant in the one after and then presents the result.
//   With the receiver ready an item passes through the event, grant and
//   output states, then returns to IDLE, in which the next event is
//   accepted; no new event is taken until the result has been taken.
// Stall: while out_tready is low the result holds and in_tready stays low.
// Reset: synchronous rst_n clears the queue, owner, blocked set and stop
//   flag and loads register defaults (hold 20000).
// ----------------------------------------------------------------------------
module token_scheduler_urgent_fifo_top import tsuf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [2:0] req_type, [6:3] guest, [7] handoff enable
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [1:0] status, [2] grant_valid, [6:3] granted_guest,
                                  // [7] owner_valid, [11:8] owner_guest
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);
  cmd_t cmd;
  result_t res;
  logic in_fire, out_fire;

  assign in_fire = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;
  assign cfg_ready = 1'b1;

  tsuf_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_fire,
    .in_ready(in_tready), .out_valid(out_tvalid), .cmd
  );

  tsuf_dp u_dp (
    .clk, .rst_n, .cmd,
    .in_req(in_tdata[2:0]), .in_guest(in_tdata[6:3]), .in_handoff(in_tdata[7]),
    .cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_val(cfg_data), .res
  );

  // Pack the result, first field in the low bits.
  assign out_tdata = {4'b0, res.owner_guest, res.owner_valid, res.granted_guest,
                      res.grant_valid, res.status};
endmodule
